// File: design/skie_pkg.sv
// Package: types, codes and sizes for the sorted key index engine.
`default_nettype none
package skie_pkg;
   localparam int Capacity = 1024;
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_FIND   = 3'd1;
   localparam logic [2:0] OP_LOCATE = 3'd2;
   localparam logic [2:0] OP_COUNT  = 3'd3;
   localparam logic [2:0] OP_FIRST  = 3'd4;

   localparam logic [1:0] OC_OK   = 2'd0;
   localparam logic [1:0] OC_MISS = 2'd1;
   localparam logic [1:0] OC_DUP  = 2'd2;
   localparam logic [1:0] OC_FULL = 2'd3;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] offset;
      logic [7:0]  status;
      logic [7:0]  flags;
   } entry_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] search_key;
      logic [31:0] record_offset;
      logic [7:0]  record_status;
      logic [7:0]  flag_byte;
      logic [7:0]  must_set;
      logic [7:0]  must_clear;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [9:0]  position;
      logic [31:0] entry_key;
      logic [31:0] entry_offset;
      logic [7:0]  entry_status;
      logic [7:0]  entry_flags;
      logic [10:0] match_count;
   } rsp_type;
endpackage
`default_nettype wire

// File: design/skie_req_if.sv
// Interface: request channel.
`default_nettype none
interface skie_req_if;
   import skie_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/skie_rsp_if.sv
// Interface: response channel.
`default_nettype none
interface skie_rsp_if;
   import skie_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/skie_store.sv
// Entry store: synchronous single-port-write, single-read memory.
`default_nettype none
module skie_store (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [skie_pkg::IdxW-1:0] wr_addr,
   input  wire skie_pkg::entry_type     wr_data,
   input  wire logic [skie_pkg::IdxW-1:0] rd_addr,
   output skie_pkg::entry_type          rd_data
);
   import skie_pkg::*;
   entry_type mem [Capacity];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/sorted_key_index_engine_unit.sv
// Top level: sorted key table with search, insert and flag scans.
// Usage:
//   req (sink): one operation per beat; rsp (source): one result per beat.
//   One request is processed at a time; ready is low while busy or while
//   a result waits in the output register.
//   Operation steps (n = stored entries; the binary search takes at most
//   floor(log2(n))+1 steps):
//     find/locate, and insert of a duplicate or into a full table: the
//     binary search, then a read of the entry at the found position.
//     insert: the same, then each entry from the found position up is read
//     and written one place up, then the new entry is written. count/first:
//     one memory read per entry scanned, n at most. Store reads are registered.
//   Reset clears the entry count and control; store contents are ignored
//   until written. When rsp stalls the result holds and no new request
//   is taken.
`default_nettype none
module sorted_key_index_engine_unit (
   input wire logic clock,
   input wire logic reset,
   skie_req_if.sink   req,
   skie_rsp_if.source rsp
);
   import skie_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BSRD  = 3'd1;
   localparam logic [2:0] S_BSCMP = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_SHRD  = 3'd4;
   localparam logic [2:0] S_SHWR  = 3'd5;
   localparam logic [2:0] S_SCAN  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CntW-1:0] ptr_ff, ptr_in;
   logic [CntW-1:0] mcnt_ff, mcnt_in;
   logic rvalid_ff, rvalid_in;
   req_type rq_ff, rq_in;
   rsp_type rs_ff, rs_in;
   logic rspv_ff, rspv_in;

   logic wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic [CntW-1:0] mid;
   logic match;
   entry_type new_e;

   skie_store u_store (.clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data));

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign match = ((rd_data.flags & rq_ff.must_set) == rq_ff.must_set) &&
      ((rd_data.flags & rq_ff.must_clear) == 8'd0);
   assign new_e = '{key: rq_ff.search_key, offset: rq_ff.record_offset,
      status: rq_ff.record_status, flags: rq_ff.flag_byte};

   assign req.ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp.valid = rspv_ff;
   assign rsp.payload = rs_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      mcnt_in = mcnt_ff;
      rvalid_in = 1'b0;
      rq_in = rq_ff;
      rs_in = rs_ff;
      rspv_in = rspv_ff && !rsp.ready;
      wr_en = 1'b0;
      wr_addr = ptr_ff[IdxW-1:0];
      wr_data = rd_data;
      rd_addr = mid[IdxW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               rq_in = req.payload;
               rs_in = '0;
               rs_in.outcome = OC_MISS;
               lo_in = '0;
               hi_in = count_ff;
               ptr_in = '0;
               mcnt_in = '0;
               case (req.payload.operation)
                  OP_INSERT, OP_FIND, OP_LOCATE: state_in = S_BSRD;
                  OP_COUNT, OP_FIRST: state_in = S_SCAN;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_BSRD: begin
            if (lo_ff < hi_ff) begin
               state_in = S_BSCMP;
            end else begin
               rd_addr = lo_ff[IdxW-1:0];
               state_in = S_DECIDE;
            end
         end
         S_BSCMP: begin
            if (rd_data.key < rq_ff.search_key) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = S_BSRD;
         end
         S_DECIDE: begin
            rs_in.position = lo_ff[9:0];
            state_in = S_DONE;
            if (lo_ff < count_ff && (rq_ff.operation != OP_LOCATE ?
                  rd_data.key == rq_ff.search_key : 1'b1)) begin
               rs_in.outcome = (rq_ff.operation == OP_INSERT) ? OC_DUP : OC_OK;
               rs_in.entry_key = rd_data.key;
               rs_in.entry_offset = rd_data.offset;
               rs_in.entry_status = rd_data.status;
               rs_in.entry_flags = rd_data.flags;
            end else if (rq_ff.operation == OP_INSERT) begin
               if (count_ff >= CntW'(Capacity)) begin
                  rs_in.outcome = OC_FULL;
               end else begin
                  ptr_in = count_ff;
                  state_in = S_SHRD;
               end
            end else begin
               rs_in.position = '0;
            end
         end
         S_SHRD: begin
            rd_addr = IdxW'(ptr_ff - 1'b1);
            if (ptr_ff > lo_ff) begin
               state_in = S_SHWR;
            end else begin
               wr_en = 1'b1;
               wr_addr = lo_ff[IdxW-1:0];
               wr_data = new_e;
               count_in = count_ff + 1'b1;
               rs_in.outcome = OC_OK;
               rs_in.position = lo_ff[9:0];
               rs_in.entry_key = new_e.key;
               rs_in.entry_offset = new_e.offset;
               rs_in.entry_status = new_e.status;
               rs_in.entry_flags = new_e.flags;
               state_in = S_DONE;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1;
            ptr_in = ptr_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_SCAN: begin
            rd_addr = ptr_ff[IdxW-1:0];
            if (rvalid_ff && match) begin
               mcnt_in = mcnt_ff + 1'b1;
            end
            if (rvalid_ff && match && rq_ff.operation == OP_FIRST) begin
               rs_in.outcome = OC_OK;
               rs_in.position = 10'(ptr_ff - 1'b1);
               rs_in.entry_key = rd_data.key;
               rs_in.entry_offset = rd_data.offset;
               rs_in.entry_status = rd_data.status;
               rs_in.entry_flags = rd_data.flags;
               state_in = S_DONE;
            end else if (ptr_ff < count_ff) begin
               rvalid_in = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end else begin
               if (rq_ff.operation == OP_COUNT) begin
                  rs_in.outcome = OC_OK;
                  rs_in.match_count = 11'(mcnt_in);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rspv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rspv_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rspv_ff <= rspv_in;
         rvalid_ff <= rvalid_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      mcnt_ff <= mcnt_in;
      rq_ff <= rq_in;
      rs_ff <= rs_in;
   end
endmodule
`default_nettype wire

// File: tb/tb_sorted_key_index_engine_unit.sv
// Testbench: sorted key index engine against a behavioral table model.
`timescale 1ns / 100ps
`default_nettype none
module tb_sorted_key_index_engine_unit;
   import skie_pkg::*;

   localparam logic [2:0] OP_BAD_A = 3'd5;
   localparam logic [2:0] OP_BAD_B = 3'd6;
   localparam logic [2:0] OP_BAD_C = 3'd7;
   localparam int IdleLimit = 40000;
   localparam int RandomItems = 520;

   logic clock;
   logic reset;
   skie_req_if req_ch ();
   skie_rsp_if rsp_ch ();

   sorted_key_index_engine_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   // table model
   entry_type table_model[Capacity];
   int unsigned table_count;
   rsp_type expected_rsps[$];
   logic [31:0] known_keys[$];
   int error_count = 0;
   int idle_cycles;
   int burst_left;
   int stall_mode;
   int stall_timer;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int unsigned lower_bound_index(logic [31:0] k);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = table_count;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         if (table_model[mid].key < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic logic flags_hit(logic [7:0] f, logic [7:0] ms, logic [7:0] mc);
      return ((f & ms) == ms) && ((f & mc) == 8'h00);
   endfunction

   function automatic rsp_type entry_rsp(logic [1:0] oc, int unsigned idx);
      rsp_type r;
      r = '0;
      r.outcome = oc;
      r.position = idx[9:0];
      r.entry_key = table_model[idx].key;
      r.entry_offset = table_model[idx].offset;
      r.entry_status = table_model[idx].status;
      r.entry_flags = table_model[idx].flags;
      return r;
   endfunction

   function automatic rsp_type apply_request(req_type q);
      rsp_type r;
      int unsigned pos, cnt;
      r = '0;
      r.outcome = OC_MISS;
      case (q.operation)
         OP_INSERT: begin
            pos = lower_bound_index(q.search_key);
            if (pos < table_count && table_model[pos].key == q.search_key) begin
               r = entry_rsp(OC_DUP, pos);
            end else if (table_count >= Capacity) begin
               r.outcome = OC_FULL;
               r.position = pos[9:0];
            end else begin
               for (int unsigned i = table_count; i > pos; i--)
                  table_model[i] = table_model[i - 1];
               table_model[pos] = {q.search_key, q.record_offset, q.record_status, q.flag_byte};
               table_count++;
               known_keys.push_back(q.search_key);
               r = entry_rsp(OC_OK, pos);
            end
         end
         OP_FIND: begin
            pos = lower_bound_index(q.search_key);
            if (pos < table_count && table_model[pos].key == q.search_key)
               r = entry_rsp(OC_OK, pos);
         end
         OP_LOCATE: begin
            pos = lower_bound_index(q.search_key);
            if (pos < table_count) r = entry_rsp(OC_OK, pos);
         end
         OP_COUNT: begin
            cnt = 0;
            for (int unsigned i = 0; i < table_count; i++)
               if (flags_hit(table_model[i].flags, q.must_set, q.must_clear)) cnt++;
            r.outcome = OC_OK;
            r.match_count = cnt[10:0];
         end
         OP_FIRST: begin
            for (int unsigned i = 0; i < table_count; i++) begin
               if (flags_hit(table_model[i].flags, q.must_set, q.must_clear)) begin
                  r = entry_rsp(OC_OK, i);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // sender: bursts with random gaps; valid stays up between beats of a burst
   task automatic send(req_type q);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.payload <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsps.push_back(apply_request(q));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [2:0] op, logic [31:0] k);
      req_type q;
      q.operation = op;
      q.search_key = k;
      q.record_offset = $urandom();
      q.record_status = 8'($urandom());
      q.flag_byte = 8'($urandom());
      q.must_set = 8'($urandom());
      q.must_clear = 8'($urandom());
      return q;
   endfunction

   task automatic send_masks(logic [2:0] op, logic [7:0] ms, logic [7:0] mc);
      req_type q;
      q = make_req(op, $urandom());
      q.must_set = ms;
      q.must_clear = mc;
      send(q);
   endtask

   task automatic test_directed();
      req_type q;
      send(make_req(OP_FIND, 32'h0000_0000));
      send(make_req(OP_LOCATE, 32'hFFFF_FFFF));
      send_masks(OP_COUNT, 8'h00, 8'h00);
      send_masks(OP_FIRST, 8'h00, 8'h00);
      q = make_req(OP_INSERT, 32'hFFFF_FFFF);
      q.record_offset = 32'hFFFF_FFFF;
      q.record_status = 8'hFF;
      q.flag_byte = 8'hFF;
      send(q);
      q = make_req(OP_INSERT, 32'h0000_0000);
      q.record_offset = 32'h0;
      q.record_status = 8'h00;
      q.flag_byte = 8'h00;
      send(q);
      send(make_req(OP_INSERT, 32'h8000_0000));
      send(make_req(OP_INSERT, 32'h7FFF_FFFF));
      send(make_req(OP_INSERT, 32'h8000_0000));   // duplicate
      send(make_req(OP_FIND, 32'h7FFF_FFFF));
      send(make_req(OP_FIND, 32'h1234_5678));
      send(make_req(OP_LOCATE, 32'h0000_0001));
      send(make_req(OP_LOCATE, 32'h0000_0000));
      send_masks(OP_COUNT, 8'hFF, 8'h00);
      send_masks(OP_COUNT, 8'h00, 8'hFF);
      send_masks(OP_COUNT, 8'h00, 8'h00);
      send_masks(OP_FIRST, 8'hFF, 8'h00);
      send_masks(OP_FIRST, 8'h00, 8'hFF);
      send_masks(OP_FIRST, 8'hFF, 8'hFF);
      send(make_req(OP_BAD_A, 32'h7FFF_FFFF));
      send(make_req(OP_BAD_B, 32'h0));
      send(make_req(OP_BAD_C, 32'hFFFF_FFFF));
      drain();
   endtask

   function automatic logic [31:0] pick_key();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (known_keys.size() == 0 || sel < 3) return $urandom();
      if (sel < 8) return known_keys[$urandom_range(0, known_keys.size() - 1)];
      return known_keys[$urandom_range(0, known_keys.size() - 1)] + (sel == 8 ? 1 : -1);
   endfunction

   task automatic test_random(int n);
      int unsigned sel;
      req_type q;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            q = make_req(OP_INSERT, (sel < 30) ? ($urandom() & 32'hEFFF_FFFF) : pick_key());
         end else if (sel < 60) q = make_req(OP_FIND, pick_key());
         else if (sel < 75) q = make_req(OP_LOCATE, pick_key());
         else if (sel < 85) q = make_req(OP_COUNT, 32'h0);
         else if (sel < 95) q = make_req(OP_FIRST, 32'h0);
         else q = make_req(3'($urandom_range(5, 7)), pick_key());
         if (q.operation == OP_COUNT || q.operation == OP_FIRST) begin
            if ($urandom_range(0, 1)) q.must_set &= 8'($urandom());
            if ($urandom_range(0, 1)) q.must_clear &= ~q.must_set & 8'($urandom());
         end
         send(q);
      end
   endtask

   task automatic test_pause_until_drained();
      test_random(10);
      drain();
      test_random(10);
      drain();
   endtask

   task automatic test_fill_to_capacity();
      int unsigned i;
      i = 0;
      while (table_count < Capacity) begin
         send(make_req(OP_INSERT, 32'hF000_0000 + i));
         i++;
      end
      drain();
   endtask

   task automatic test_full_table();
      send(make_req(OP_INSERT, 32'hFFFF_FFFF));   // duplicate wins over full
      send(make_req(OP_INSERT, 32'hFFFF_FFFE));
      send(make_req(OP_INSERT, 32'h0000_0001));
      send(make_req(OP_FIND, 32'hFFFF_FFFF));
      send(make_req(OP_LOCATE, 32'hF000_0000));
      send_masks(OP_COUNT, 8'h00, 8'h00);
      send_masks(OP_FIRST, 8'h00, 8'h00);
      test_random(20);
      drain();
   endtask

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_timer <= 0;
         stall_mode <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 120);
         end else stall_timer <= stall_timer - 1;
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsps.size() == 0) begin
               report("unexpected beat", 32'(got.outcome), 32'h0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.outcome !== want.outcome)
                  report("outcome", 32'(got.outcome), 32'(want.outcome));
               if (got.position !== want.position)
                  report("position", 32'(got.position), 32'(want.position));
               if (got.entry_key !== want.entry_key)
                  report("entry_key", got.entry_key, want.entry_key);
               if (got.entry_offset !== want.entry_offset)
                  report("entry_offset", got.entry_offset, want.entry_offset);
               if (got.entry_status !== want.entry_status)
                  report("entry_status", 32'(got.entry_status), 32'(want.entry_status));
               if (got.entry_flags !== want.entry_flags)
                  report("entry_flags", 32'(got.entry_flags), 32'(want.entry_flags));
               if (got.match_count !== want.match_count)
                  report("match_count", 32'(got.match_count), 32'(want.match_count));
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("tb_sorted_key_index_engine_unit failed");
         $finish;
      end
   end

   initial begin
      burst_left = 0;
      table_count = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(RandomItems / 2);
      test_pause_until_drained();
      test_random(RandomItems / 2);
      drain();
      test_fill_to_capacity();
      test_full_table();
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("tb_sorted_key_index_engine_unit passed");
      end else begin
         $display("tb_sorted_key_index_engine_unit failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
design/skie_pkg.sv
design/skie_req_if.sv
design/skie_rsp_if.sv
design/skie_store.sv
design/sorted_key_index_engine_unit.sv
tb/tb_sorted_key_index_engine_unit.sv
